>>> rtl/tfve_pkg.sv
// Shared types and constants of the terrain fan vertex emitter.
`timescale 1ns / 1ps

package tfve_pkg;

    localparam int COORD_W    = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int PPS_W      = 7;
    localparam int PIDX_W     = 6;
    localparam int FIDX_W     = 8;
    localparam int LOD_W      = 3;
    localparam int NUM_LOD    = 8;

    localparam logic [COORD_W-1:0] COORD_MAX = 23'h7FFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_SIZE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCHES_PER_SIDE = 2'd1;

    typedef logic [3:0] t_point;

    localparam t_point PT_C  = 4'd0;
    localparam t_point PT_L  = 4'd1;
    localparam t_point PT_LU = 4'd2;
    localparam t_point PT_U  = 4'd3;
    localparam t_point PT_RU = 4'd4;
    localparam t_point PT_R  = 4'd5;
    localparam t_point PT_RD = 4'd6;
    localparam t_point PT_D  = 4'd7;
    localparam t_point PT_LD = 4'd8;

    typedef struct packed {
        logic l;
        logic r;
        logic d;
        logic u;
    } t_keep;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cz;
        logic [COORD_W-1:0] xl;
        logic [COORD_W-1:0] xr;
        logic [COORD_W-1:0] zd;
        logic [COORD_W-1:0] zu;
        t_keep              keep;
    } t_fan;

endpackage

>>> rtl/tfve_size_tbl.sv
// Fan spacing table: one restoring divider fills the spacing for every level of detail.
`timescale 1ns / 1ps

module tfve_size_tbl #(
    parameter int PSW       = 9,
    parameter int FRAC_BITS = 8
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_start,
    input  logic [PSW-1:0]                                     i_ps,
    output logic                                               o_busy,
    output logic [tfve_pkg::NUM_LOD-1:0][PSW+FRAC_BITS-1:0]    o_size,
    output logic [tfve_pkg::NUM_LOD-1:0][PSW-1:0]              o_div
);
    import tfve_pkg::*;

    localparam int QW   = PSW + FRAC_BITS;
    localparam int CNTW = $clog2(QW + 1);

    logic                              r_busy;
    logic [LOD_W-1:0]                  r_lod;
    logic [CNTW-1:0]                   r_cnt;
    logic [PSW-1:0]                    r_rem;
    logic [QW-1:0]                     r_dvd;
    logic [QW-1:0]                     r_quo;
    logic [NUM_LOD-1:0][QW-1:0]        r_size;

    logic [PSW-1:0]                    ps_m1;
    logic [PSW-1:0]                    cur_div;
    logic [PSW:0]                      trial;
    logic                              fits;
    logic [PSW-1:0]                    n_rem;
    logic [QW-1:0]                     n_quo;

    always_comb begin
        logic [PSW-1:0] sh;
        ps_m1 = (i_ps == '0) ? '0 : i_ps - 1'b1;
        for (int l = 0; l < NUM_LOD; l++) begin
            sh = ps_m1 >> l;
            o_div[l] = (sh == '0) ? PSW'(1) : sh;
        end
    end

    assign cur_div = o_div[r_lod];
    assign trial   = {r_rem, r_dvd[QW-1]};
    assign fits    = trial >= {1'b0, cur_div};
    assign n_rem   = fits ? PSW'(trial - {1'b0, cur_div}) : trial[PSW-1:0];
    assign n_quo   = {r_quo[QW-2:0], fits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_lod  <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNTW'(QW)) begin
                r_cnt <= '0;
                if (r_lod == LOD_W'(NUM_LOD - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_lod <= r_lod + 1'b1;
                end
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_cnt == '0) begin
                r_dvd <= (QW'(i_ps)) << FRAC_BITS;
                r_rem <= '0;
                r_quo <= '0;
            end else begin
                r_dvd <= {r_dvd[QW-2:0], 1'b0};
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == CNTW'(QW)) begin
                    r_size[r_lod] <= n_quo;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_size = r_size;

endmodule

>>> rtl/tfve_geom.sv
// Four-stage pipeline that turns a fan request into its centre, ring coordinates and side flags.
`timescale 1ns / 1ps

module tfve_geom #(
    parameter int PSW       = 9,
    parameter int FRAC_BITS = 8
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_valid,
    output logic                                               o_ready,
    input  logic [tfve_pkg::PIDX_W-1:0]                        i_patch_x,
    input  logic [tfve_pkg::PIDX_W-1:0]                        i_patch_z,
    input  logic [tfve_pkg::FIDX_W-1:0]                        i_fan_x,
    input  logic [tfve_pkg::FIDX_W-1:0]                        i_fan_z,
    input  logic [tfve_pkg::LOD_W-1:0]                         i_patch_lod,
    input  logic [tfve_pkg::LOD_W-1:0]                         i_lod_left,
    input  logic [tfve_pkg::LOD_W-1:0]                         i_lod_right,
    input  logic [tfve_pkg::LOD_W-1:0]                         i_lod_down,
    input  logic [tfve_pkg::LOD_W-1:0]                         i_lod_up,
    input  logic [PSW-1:0]                                     i_ps,
    input  logic [tfve_pkg::PPS_W-1:0]                         i_pps,
    input  logic                                               i_tbl_busy,
    input  logic [tfve_pkg::NUM_LOD-1:0][PSW+FRAC_BITS-1:0]    i_size,
    input  logic [tfve_pkg::NUM_LOD-1:0][PSW-1:0]              i_div,
    output logic                                               o_fan_valid,
    output tfve_pkg::t_fan                                     o_fan,
    input  logic                                               i_fan_ready
);
    import tfve_pkg::*;

    localparam int QW = PSW + FRAC_BITS;
    localparam int CW = QW + 10;
    localparam int SW = (CW > COORD_W + 1) ? CW : COORD_W + 1;

    function automatic logic [COORD_W-1:0] sat(input logic [CW-1:0] v);
        if (SW'(v) > SW'(COORD_MAX)) begin
            sat = COORD_MAX;
        end else begin
            sat = COORD_W'(v);
        end
    endfunction

    logic en_a, en_b, en_c, en_d;
    logic r_a_v, r_b_v, r_c_v, r_d_v;

    logic [QW-1:0]     r_a_size;
    logic [PSW+5:0]    r_a_pxps, r_a_pzps;
    logic [FIDX_W-1:0] r_a_fx, r_a_fz;
    t_keep             r_a_keep;

    logic [CW-1:0]     r_b_bx, r_b_bz;
    logic [QW+7:0]     r_b_mx, r_b_mz;
    logic [QW-1:0]     r_b_half;
    t_keep             r_b_keep;

    logic [CW-1:0]     r_c_cx, r_c_cz;
    logic [QW-1:0]     r_c_half;
    t_keep             r_c_keep;

    t_fan              r_d_fan;

    logic [PSW-1:0]    a_dm1;
    logic [PSW+5:0]    a_pxps, a_pzps;
    logic              pl, pr, pd, pu;
    t_keep             a_keep;
    logic [QW+7:0]     b_mx, b_mz;
    logic [QW-1:0]     b_half;
    logic [CW-1:0]     d_xl, d_xr, d_zd, d_zu;

    assign en_d    = !r_d_v || i_fan_ready;
    assign en_c    = !r_c_v || en_d;
    assign en_b    = !r_b_v || en_c;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a && !i_tbl_busy;

    always_comb begin
        a_dm1    = i_div[i_patch_lod] - 1'b1;
        a_pxps   = i_patch_x * i_ps;
        a_pzps   = i_patch_z * i_ps;
        pl       = (i_patch_x == '0) || (i_lod_left <= i_patch_lod);
        pr       = ((8'(i_patch_x) + 8'd1) == 8'(i_pps)) || (i_lod_right <= i_patch_lod);
        pd       = (i_patch_z == '0) || (i_lod_down <= i_patch_lod);
        pu       = ((8'(i_patch_z) + 8'd1) == 8'(i_pps)) || (i_lod_up <= i_patch_lod);
        a_keep.l = (i_fan_x == '0) ? pl : 1'b1;
        a_keep.r = (32'(i_fan_x) >= 32'(a_dm1)) ? pr : 1'b1;
        a_keep.d = (i_fan_z == '0) ? pd : 1'b1;
        a_keep.u = (32'(i_fan_z) >= 32'(a_dm1)) ? pu : 1'b1;
    end

    assign b_mx   = r_a_fx * r_a_size;
    assign b_mz   = r_a_fz * r_a_size;
    assign b_half = r_a_size >> 1;

    assign d_xl = r_c_cx - CW'(r_c_half);
    assign d_xr = r_c_cx + CW'(r_c_half);
    assign d_zd = r_c_cz - CW'(r_c_half);
    assign d_zu = r_c_cz + CW'(r_c_half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= i_valid && o_ready;
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
            if (en_c) begin
                r_c_v <= r_b_v;
            end
            if (en_d) begin
                r_d_v <= r_c_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_size <= i_size[i_patch_lod];
            r_a_pxps <= a_pxps;
            r_a_pzps <= a_pzps;
            r_a_fx   <= i_fan_x;
            r_a_fz   <= i_fan_z;
            r_a_keep <= a_keep;
        end
        if (en_b) begin
            r_b_bx   <= ((CW'(r_a_pxps)) << FRAC_BITS) + CW'(b_half);
            r_b_bz   <= ((CW'(r_a_pzps)) << FRAC_BITS) + CW'(b_half);
            r_b_mx   <= b_mx;
            r_b_mz   <= b_mz;
            r_b_half <= b_half;
            r_b_keep <= r_a_keep;
        end
        if (en_c) begin
            r_c_cx   <= r_b_bx + CW'(r_b_mx);
            r_c_cz   <= r_b_bz + CW'(r_b_mz);
            r_c_half <= r_b_half;
            r_c_keep <= r_b_keep;
        end
        if (en_d) begin
            r_d_fan.cx   <= sat(r_c_cx);
            r_d_fan.cz   <= sat(r_c_cz);
            r_d_fan.xl   <= sat(d_xl);
            r_d_fan.xr   <= sat(d_xr);
            r_d_fan.zd   <= sat(d_zd);
            r_d_fan.zu   <= sat(d_zu);
            r_d_fan.keep <= r_c_keep;
        end
    end

    assign o_fan_valid = r_d_v;
    assign o_fan       = r_d_fan;

endmodule

>>> rtl/tfve_strip.sv
// Strip sequencer: walks one fan's ring and drives the registered vertex output.
`timescale 1ns / 1ps

module tfve_strip (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fan_valid,
    input  tfve_pkg::t_fan                    i_fan,
    output logic                              o_fan_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tfve_pkg::COORD_W-1:0]      o_vert_x,
    output logic [tfve_pkg::COORD_W-1:0]      o_vert_z,
    output logic                              o_strip_end
);
    import tfve_pkg::*;

    localparam logic [2:0] ST_HEAD0 = 3'd0;
    localparam logic [2:0] ST_HEAD1 = 3'd1;
    localparam logic [2:0] ST_RING  = 3'd2;
    localparam logic [2:0] ST_MID   = 3'd3;
    localparam logic [2:0] ST_CLOSE = 3'd4;

    localparam logic [3:0] SLOT_LAST = 4'd8;
    localparam logic [3:0] SLOT_DONE = 4'd9;

    function automatic t_point slot_pt(input logic [3:0] k, input logic keep_l);
        unique case (k)
            4'd0:    slot_pt = PT_L;
            4'd1:    slot_pt = PT_LU;
            4'd2:    slot_pt = PT_U;
            4'd3:    slot_pt = PT_RU;
            4'd4:    slot_pt = PT_R;
            4'd5:    slot_pt = PT_RD;
            4'd6:    slot_pt = PT_D;
            4'd7:    slot_pt = PT_LD;
            default: slot_pt = keep_l ? PT_L : PT_LU;
        endcase
    endfunction

    function automatic logic [2*COORD_W-1:0] pt_xz(input t_point p, input t_fan f);
        unique case (p)
            PT_L:    pt_xz = {f.xl, f.cz};
            PT_LU:   pt_xz = {f.xl, f.zu};
            PT_U:    pt_xz = {f.cx, f.zu};
            PT_RU:   pt_xz = {f.xr, f.zu};
            PT_R:    pt_xz = {f.xr, f.cz};
            PT_RD:   pt_xz = {f.xr, f.zd};
            PT_D:    pt_xz = {f.cx, f.zd};
            PT_LD:   pt_xz = {f.xl, f.zd};
            default: pt_xz = {f.cx, f.cz};
        endcase
    endfunction

    logic                r_busy;
    logic [2:0]          r_st;
    logic [3:0]          r_k;
    logic                r_pair;
    t_point              r_last;
    t_fan                r_fan;
    logic                r_ov;
    logic [COORD_W-1:0]  r_x, r_z;
    logic                r_end;

    logic [2:0]          n_st;
    logic [3:0]          n_k;
    logic                n_pair;
    logic [3:0]          eff;
    logic                skip;
    t_point              pt;
    logic                last_flag;
    logic                adv, emit, take;

    assign adv         = !r_ov || i_out_ready;
    assign emit        = r_busy && adv;
    assign take        = !r_busy || ((r_st == ST_CLOSE) && adv);
    assign o_fan_ready = take;

    always_comb begin
        case (r_k)
            4'd0:    skip = !r_fan.keep.l;
            4'd2:    skip = !r_fan.keep.u;
            4'd4:    skip = !r_fan.keep.r;
            4'd6:    skip = !r_fan.keep.d;
            default: skip = 1'b0;
        endcase
    end

    always_comb begin
        n_st      = r_st;
        n_k       = r_k;
        n_pair    = r_pair;
        eff       = skip ? r_k + 1'b1 : r_k;
        pt        = PT_C;
        last_flag = 1'b0;
        unique case (r_st)
            ST_HEAD0: n_st = ST_HEAD1;
            ST_HEAD1: n_st = ST_RING;
            ST_RING: begin
                pt  = slot_pt(eff, r_fan.keep.l);
                n_k = eff + 1'b1;
                if (r_pair) begin
                    n_pair = 1'b0;
                    n_st   = ST_MID;
                end else begin
                    n_pair = 1'b1;
                    n_st   = (eff == SLOT_LAST) ? ST_CLOSE : ST_RING;
                end
            end
            ST_MID:   n_st = (r_k == SLOT_DONE) ? ST_CLOSE : ST_RING;
            ST_CLOSE: begin
                pt        = r_last;
                last_flag = 1'b1;
            end
            default: n_st = ST_HEAD0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_st   <= ST_HEAD0;
            r_k    <= '0;
            r_pair <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= i_fan_valid;
                r_st   <= ST_HEAD0;
                r_k    <= '0;
                r_pair <= 1'b0;
            end else if (emit) begin
                r_st   <= n_st;
                r_k    <= n_k;
                r_pair <= n_pair;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_fan_valid) begin
            r_fan <= i_fan;
        end
        if (emit) begin
            {r_x, r_z} <= pt_xz(pt, r_fan);
            r_end      <= last_flag;
            r_last     <= pt;
        end
    end

    assign o_out_valid = r_ov;
    assign o_vert_x    = r_x;
    assign o_vert_z    = r_z;
    assign o_strip_end = r_end;

endmodule

>>> rtl/terrain_fan_vertex_emitter_core.sv
// Top level of the terrain fan vertex emitter: configuration registers and block assembly.
// A request passes the four geometry stages and the sequencer's fan and vertex registers.
// Throughput: one vertex per cycle while the output channel accepts.
// Requests enter every cycle into the four-stage geometry pipeline until it backs up.
// Reset and every patch size write start a spacing table fill;
// no request is accepted while it runs.
`timescale 1ns / 1ps

module terrain_fan_vertex_emitter_core #(
    parameter int MAX_PATCHES_PER_SIDE = 64,
    parameter int MAX_PATCH_SIZE       = 257,
    parameter int FRAC_BITS            = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [tfve_pkg::PIDX_W-1:0]           i_patch_x,
    input  logic [tfve_pkg::PIDX_W-1:0]           i_patch_z,
    input  logic [tfve_pkg::FIDX_W-1:0]           i_fan_x,
    input  logic [tfve_pkg::FIDX_W-1:0]           i_fan_z,
    input  logic [tfve_pkg::LOD_W-1:0]            i_patch_lod,
    input  logic [tfve_pkg::LOD_W-1:0]            i_lod_left,
    input  logic [tfve_pkg::LOD_W-1:0]            i_lod_right,
    input  logic [tfve_pkg::LOD_W-1:0]            i_lod_down,
    input  logic [tfve_pkg::LOD_W-1:0]            i_lod_up,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [tfve_pkg::COORD_W-1:0]          o_vert_x,
    output logic [tfve_pkg::COORD_W-1:0]          o_vert_z,
    output logic                                  o_strip_end,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tfve_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tfve_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tfve_pkg::*;

    localparam int PSW = $clog2(MAX_PATCH_SIZE + 1);
    localparam int QW  = PSW + FRAC_BITS;

    localparam logic [PSW-1:0]   PS_RESET  = PSW'((MAX_PATCH_SIZE < 17) ? MAX_PATCH_SIZE : 17);
    localparam logic [PPS_W-1:0] PPS_RESET =
        PPS_W'((MAX_PATCHES_PER_SIDE < 16) ? MAX_PATCHES_PER_SIDE : 16);

    logic [PSW-1:0]              r_ps;
    logic [PPS_W-1:0]            r_pps;
    logic [PSW-1:0]              n_ps;
    logic [PPS_W-1:0]            n_pps;
    logic                        cfg_wr;
    logic                        tbl_start;
    logic                        tbl_busy;
    logic [NUM_LOD-1:0][QW-1:0]  tbl_size;
    logic [NUM_LOD-1:0][PSW-1:0] tbl_div;
    logic                        fan_valid;
    logic                        fan_ready;
    t_fan                        fan;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign tbl_start   = cfg_wr && (i_cfg_index == CFG_PATCH_SIZE);

    assign n_ps  = (32'(i_cfg_data) > 32'(MAX_PATCH_SIZE)) ?
                   PSW'(MAX_PATCH_SIZE) : PSW'(i_cfg_data);
    assign n_pps = (32'(i_cfg_data[PPS_W-1:0]) > 32'(MAX_PATCHES_PER_SIDE)) ?
                   PPS_W'(MAX_PATCHES_PER_SIDE) : i_cfg_data[PPS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps  <= PS_RESET;
            r_pps <= PPS_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_PATCH_SIZE:       r_ps  <= n_ps;
                CFG_PATCHES_PER_SIDE: r_pps <= n_pps;
                default: ;
            endcase
        end
    end

    tfve_size_tbl #(
        .PSW       (PSW),
        .FRAC_BITS (FRAC_BITS)
    ) u_size_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tbl_start),
        .i_ps    (r_ps),
        .o_busy  (tbl_busy),
        .o_size  (tbl_size),
        .o_div   (tbl_div)
    );

    tfve_geom #(
        .PSW       (PSW),
        .FRAC_BITS (FRAC_BITS)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_patch_x   (i_patch_x),
        .i_patch_z   (i_patch_z),
        .i_fan_x     (i_fan_x),
        .i_fan_z     (i_fan_z),
        .i_patch_lod (i_patch_lod),
        .i_lod_left  (i_lod_left),
        .i_lod_right (i_lod_right),
        .i_lod_down  (i_lod_down),
        .i_lod_up    (i_lod_up),
        .i_ps        (r_ps),
        .i_pps       (r_pps),
        .i_tbl_busy  (tbl_busy),
        .i_size      (tbl_size),
        .i_div       (tbl_div),
        .o_fan_valid (fan_valid),
        .o_fan       (fan),
        .i_fan_ready (fan_ready)
    );

    tfve_strip u_strip (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fan_valid (fan_valid),
        .i_fan       (fan),
        .o_fan_ready (fan_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_vert_x    (o_vert_x),
        .o_vert_z    (o_vert_z),
        .o_strip_end (o_strip_end)
    );

`ifndef ASSERT_OFF
    a_no_accept_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !tbl_busy)
        else $error("request accepted while the spacing table is being filled");

    a_fan_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fan_valid && !fan_ready) |=> (fan_valid && $stable(fan)))
        else $error("stalled fan changed before the sequencer took it");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !fan_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule
